/* rtl/osgt_pkg.sv */
// shared types and sizes for the occupied slot gap tracker
`default_nettype none

package osgt_pkg;

  localparam int SLOTS      = 512;
  localparam int COORD_BITS = 30;

  // leaves round up to a power of two, node 1 is the root, node 0 unused
  localparam int LEAF_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEAVES    = 1 << LEAF_BITS;
  localparam int NODE_BITS = LEAF_BITS + 1;
  localparam int NODES     = 1 << NODE_BITS;

  // request kinds carried on req_type
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [NODE_BITS-1:0]  node_idx_t;

  typedef struct packed {
    logic   valid;
    coord_t lo;
    coord_t hi;
    coord_t gap;
  } node_t;

endpackage

`default_nettype wire

/* rtl/osgt_merge.sv */
// shared merge unit: combines the running node with its sibling into the parent
`default_nettype none

module osgt_merge (
  input  osgt_pkg::node_t cur,
  input  osgt_pkg::node_t sib,
  input  logic            cur_right,
  output osgt_pkg::node_t parent
);

  osgt_pkg::node_t  left;
  osgt_pkg::node_t  right;
  osgt_pkg::coord_t child_gap;
  osgt_pkg::coord_t mid;
  logic             ordered;

  assign left  = cur_right ? sib : cur;
  assign right = cur_right ? cur : sib;

  assign child_gap = (left.gap > right.gap) ? left.gap : right.gap;
  assign ordered   = right.lo > left.hi;
  // only meaningful when ordered, so it cannot underflow
  assign mid       = right.lo - left.hi - osgt_pkg::coord_t'(1);

  always_comb begin
    priority if (!left.valid) begin
      parent = right;
    end else if (!right.valid) begin
      parent = left;
    end else begin
      parent.valid = 1'b1;
      parent.lo    = left.lo;
      parent.hi    = right.hi;
      parent.gap   = (ordered && (mid > child_gap)) ? mid : child_gap;
    end
  end

endmodule

`default_nettype wire

/* rtl/osgt_node_store.sv */
// node memory of the tree: one write port, one registered read port
`default_nettype none

module osgt_node_store (
  input  logic                clk,
  input  logic                we,
  input  osgt_pkg::node_idx_t waddr,
  input  osgt_pkg::node_t     wdata,
  input  logic                re,
  input  osgt_pkg::node_idx_t raddr,
  output osgt_pkg::node_t     rdata
);

  osgt_pkg::node_t mem [osgt_pkg::NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/occupied_slot_gap_tracker_top.sv */
// top level of the occupied slot gap tracker: sequencer, node memory and merge unit
`default_nettype none

// usage
//   a request word is taken at a rising edge with start high and busy low:
//   req_type selects an update of one slot or a clear of all slots
//   every request gives one result word on done, high for exactly one cycle,
//   showing the root: any_present, min_coord, max_coord, largest_gap (zeros
//   when no slot is occupied); the receiver must take it, there is no stall
// timing
//   update: the leaf is written at the accept edge, then each of the
//   LEAF_BITS levels takes a sibling read (ST_RD) and then a merge and parent
//   write (ST_MG) through the single memory port pair and the one merge unit,
//   and done rises at the edge that writes the root; start may be raised again
//   in the done cycle
//   clear: a pass over all NODES entries, one per cycle, then done
//   slot at or above SLOTS: the root is read back, then done
// reset
//   rst (synchronous) starts the same clearing pass with busy high; it gives
//   no result word
module occupied_slot_gap_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [8:0]  slot,
  input  logic        present,
  input  logic [29:0] coordinate,
  output logic        done,
  output logic        any_present,
  output logic [29:0] min_coord,
  output logic [29:0] max_coord,
  output logic [29:0] largest_gap
);

  localparam int NB = osgt_pkg::NODE_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_MG    = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_ROOTW = 3'd5;

  localparam logic [9:0]          SLOT_LIMIT = 10'(osgt_pkg::SLOTS);
  localparam osgt_pkg::node_idx_t ROOT_IDX   = NB'(1);
  localparam osgt_pkg::node_idx_t LEAF_BASE  = NB'(osgt_pkg::LEAVES);

  logic [2:0]          state;
  osgt_pkg::node_idx_t idx;       // node on the path, or sweep address
  logic                report;    // sweep was a clear request, answer it
  osgt_pkg::node_t     cur;       // node just written on the path
  osgt_pkg::node_t     result;

  logic                accept;
  logic                in_range;
  osgt_pkg::node_idx_t leaf_addr;
  osgt_pkg::node_t     leaf_node;
  osgt_pkg::node_idx_t parent_idx;
  osgt_pkg::node_t     merged;

  logic                we;
  osgt_pkg::node_idx_t waddr;
  osgt_pkg::node_t     wdata;
  logic                re;
  osgt_pkg::node_idx_t raddr;
  osgt_pkg::node_t     rdata;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign in_range   = {1'b0, slot} < SLOT_LIMIT;
  assign leaf_addr  = LEAF_BASE + NB'(slot);
  assign parent_idx = {1'b0, idx[NB-1:1]};

  // a cleared leaf holds zeros with its valid bit low
  always_comb begin
    leaf_node = '0;
    if (present) begin
      leaf_node.valid = 1'b1;
      leaf_node.lo    = osgt_pkg::coord_t'(coordinate);
      leaf_node.hi    = osgt_pkg::coord_t'(coordinate);
    end
  end

  osgt_node_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cur sits at idx, its sibling has come back from the memory
  osgt_merge u_merge (
    .cur       (cur),
    .sib       (rdata),
    .cur_right (idx[0]),
    .parent    (merged)
  );

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    re    = 1'b0;
    raddr = idx;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req_type == osgt_pkg::REQ_UPDATE) && in_range) begin
          we    = 1'b1;
          waddr = leaf_addr;
          wdata = leaf_node;
        end
      end
      ST_SWEEP: begin
        we = 1'b1;
      end
      ST_RD: begin
        re    = 1'b1;
        raddr = {idx[NB-1:1], ~idx[0]};
      end
      ST_MG: begin
        we    = 1'b1;
        waddr = parent_idx;
        wdata = merged;
      end
      ST_ROOT: begin
        re    = 1'b1;
        raddr = ROOT_IDX;
      end
      ST_ROOTW: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_SWEEP;
      idx    <= '0;
      report <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == osgt_pkg::REQ_CLEAR) begin
              state  <= ST_SWEEP;
              idx    <= '0;
              report <= 1'b1;
            end else if (in_range) begin
              state <= ST_RD;
              idx   <= leaf_addr;
            end else begin
              state <= ST_ROOT;
            end
          end
        end
        ST_SWEEP: begin
          idx <= idx + NB'(1);
          if (&idx) begin
            state <= ST_IDLE;
            done  <= report;
          end
        end
        ST_RD: begin
          state <= ST_MG;
        end
        ST_MG: begin
          idx <= parent_idx;
          if (parent_idx == ROOT_IDX) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_RD;
          end
        end
        ST_ROOT: begin
          state <= ST_ROOTW;
        end
        ST_ROOTW: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload: path node and result word, an empty root reports zeros
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur <= leaf_node;
        end
      end
      ST_SWEEP: begin
        result <= '0;
      end
      ST_MG: begin
        cur    <= merged;
        result <= merged.valid ? merged : '0;
      end
      ST_ROOTW: begin
        result <= rdata.valid ? rdata : '0;
      end
      default: begin
      end
    endcase
  end

  assign any_present = result.valid;
  assign min_coord   = 30'(result.lo);
  assign max_coord   = 30'(result.hi);
  assign largest_gap = 30'(result.gap);

endmodule

`default_nettype wire

/* rtl/osgt_checker.sv */
// port level checks of the tracker and their binding to the top level
`default_nettype none

module osgt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        any_present,
  input logic [29:0] min_coord,
  input logic [29:0] max_coord,
  input logic [29:0] largest_gap
);

  // every accepted request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // a result word closes its request
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result words back to back");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !any_present) |-> (min_coord == 30'd0 && max_coord == 30'd0
                                && largest_gap == 30'd0))
    else $error("empty tree reported nonzero fields");

  // the clearing pass follows reset
  a_reset_sweep: assert property (@(posedge clk)
    $fell(rst) |-> (busy && !done))
    else $error("block not clearing after reset");

endmodule

bind occupied_slot_gap_tracker_top osgt_checker u_osgt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .any_present (any_present),
  .min_coord   (min_coord),
  .max_coord   (max_coord),
  .largest_gap (largest_gap)
);

`default_nettype wire
